[rtl/uer_pkg.sv]
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; used by uer_ranging_fsm, the top level and uer_checker.
`default_nettype none

package uer_pkg;

    // Pulse counter width (valid range 8 to 32)
    localparam int CNT_W  = 16;
    localparam int CMP_W  = (CNT_W > 16) ? CNT_W : 16;
    localparam int PROD_W = CNT_W + 9;
    localparam int DIST_W = (CNT_W + 1 > 17) ? CNT_W + 1 : 17;

    localparam int PRE_LOW_TICKS = 2;
    localparam int DIST_MUL      = 439;
    localparam int DIST_SHIFT    = 8;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_W    = 2'd2;

    localparam logic [15:0] TIMEOUT_RST   = 16'd25000;
    localparam logic [15:0] THRESHOLD_RST = 16'd3000;
    localparam logic [7:0]  TRIG_W_RST    = 8'd10;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_STUCK   = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    // Result bit positions inside m_tdata
    localparam int POS_TRIG     = 0;
    localparam int POS_BUSY     = 1;
    localparam int POS_DONE     = 2;
    localparam int POS_STATUS   = 3;
    localparam int POS_DIST     = 5;
    localparam int POS_OBSTACLE = 21;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [15:0] threshold_centi_cm;
        logic [7:0]  trigger_width_ticks;
    } cfg_t;

    // Packed so that trigger_level lands in bit 0
    typedef struct packed {
        logic        obstacle;
        logic [15:0] distance_centi_cm;
        logic [1:0]  status;
        logic        done_res;
        logic        busy_res;
        logic        trigger_level;
    } result_t;

endpackage

`default_nettype wire

[rtl/uer_ranging_fsm.sv]
// Ranging sequencer: trigger timing, echo wait/measure, distance and obstacle.
// Depends on uer_pkg.
`default_nettype none

module uer_ranging_fsm (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire logic           cmd,
    input  wire logic           echo_level,
    input  wire uer_pkg::cfg_t  cfg,
    output uer_pkg::result_t    result
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LOW,
        PH_TRIG,
        PH_WAIT,
        PH_MEAS
    } phase_t;

    phase_t                    phase_reg, phase_next;
    logic [uer_pkg::CNT_W-1:0] tick_reg, tick_next;
    logic [15:0]               dist_reg, dist_next;
    logic [1:0]                status_reg, status_next;
    logic                      obst_reg, obst_next;

    logic [uer_pkg::CNT_W-1:0]  tick_inc;
    logic                       over_limit;
    logic                       trig;
    logic                       done;
    logic [uer_pkg::PROD_W-1:0] prod;
    logic [uer_pkg::DIST_W-1:0] dist_full;
    logic [15:0]                dist_sat;

    assign tick_inc   = tick_reg + uer_pkg::CNT_W'(1);
    assign over_limit = (uer_pkg::CMP_W'(tick_reg) >= uer_pkg::CMP_W'(cfg.timeout_ticks))
                        || (tick_reg == '1);

    assign prod      = uer_pkg::PROD_W'(tick_reg) * uer_pkg::PROD_W'(uer_pkg::DIST_MUL);
    assign dist_full = uer_pkg::DIST_W'(prod >> uer_pkg::DIST_SHIFT);
    assign dist_sat  = (dist_full > uer_pkg::DIST_W'(16'hFFFF)) ? 16'hFFFF : dist_full[15:0];

    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        dist_next   = dist_reg;
        status_next = status_reg;
        obst_next   = obst_reg;
        trig        = 1'b0;
        done        = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (cmd)
                begin
                    if (echo_level)
                    begin
                        status_next = uer_pkg::ST_STUCK;
                        obst_next   = 1'b0;
                        tick_next   = '0;
                        done        = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_LOW;
                        tick_next  = uer_pkg::CNT_W'(1);
                    end
                end
            end
            PH_LOW:
            begin
                tick_next = tick_inc;
                if (tick_inc >= uer_pkg::CNT_W'(uer_pkg::PRE_LOW_TICKS))
                begin
                    phase_next = PH_TRIG;
                    tick_next  = '0;
                end
            end
            PH_TRIG:
            begin
                trig      = 1'b1;
                tick_next = tick_inc;
                if (uer_pkg::CMP_W'(tick_inc) >= uer_pkg::CMP_W'(cfg.trigger_width_ticks))
                begin
                    phase_next = PH_WAIT;
                    tick_next  = '0;
                end
            end
            PH_WAIT:
            begin
                if (echo_level)
                begin
                    phase_next = PH_MEAS;
                    tick_next  = uer_pkg::CNT_W'(1);
                end
                else if (over_limit)
                begin
                    phase_next  = PH_IDLE;
                    tick_next   = '0;
                    status_next = uer_pkg::ST_TIMEOUT;
                    obst_next   = 1'b0;
                    done        = 1'b1;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            PH_MEAS:
            begin
                if (!echo_level)
                begin
                    phase_next  = PH_IDLE;
                    tick_next   = '0;
                    dist_next   = dist_sat;
                    status_next = uer_pkg::ST_OK;
                    obst_next   = (dist_sat != 16'd0) && (dist_sat <= cfg.threshold_centi_cm);
                    done        = 1'b1;
                end
                else if (over_limit)
                begin
                    phase_next  = PH_IDLE;
                    tick_next   = '0;
                    status_next = uer_pkg::ST_TIMEOUT;
                    obst_next   = 1'b0;
                    done        = 1'b1;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                tick_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            tick_reg   <= '0;
            dist_reg   <= '0;
            status_reg <= uer_pkg::ST_OK;
            obst_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            dist_reg   <= dist_next;
            status_reg <= status_next;
            obst_reg   <= obst_next;
        end
    end

    always_comb
    begin
        result.trigger_level     = trig;
        result.busy_res          = (phase_next != PH_IDLE);
        result.done_res          = done;
        result.status            = status_next;
        result.distance_centi_cm = dist_next;
        result.obstacle          = obst_next;
    end

endmodule

`default_nettype wire

[rtl/ultrasonic_echo_ranger.sv]
// Top level of the ultrasonic echo ranger: config registers and output skid buffer.
// Depends on uer_pkg and uer_ranging_fsm.
//
// Usage:
//   Each slave transaction is one microsecond tick: s_tdata[0] is the sampled
//   echo level, s_tuser[0] requests a measurement. Every accepted tick yields
//   exactly one master transaction with the trigger level to drive, busy,
//   done, last status, last distance (hundredths of a cm) and obstacle flag.
//   Each result is registered in the result register (via skid on a stall).
//   Throughput: one tick per cycle unless a full output drops s_tready;
//   the sequencer and the distance multiply (16x9 bits) are combinational.
//   The output side has a result register plus a one-entry skid register, so
//   s_tready depends only on the skid register and one more tick is taken
//   while the receiver stalls; s_tready drops once both are full.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next
//   edge: 0 timeout_ticks, 1 threshold_centi_cm, 2 trigger_width_ticks; any
//   other index is ignored. Write only while no measurement runs.
//   Reset: asynchronous, active low; sequencer idle, status ok, distance 0,
//   no obstacle, output buffers empty, registers at their defaults.
`default_nettype none

module ultrasonic_echo_ranger (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    input  wire logic [uer_pkg::S_TDATA_W-1:0]   s_tdata,   // [0] echo_level
    input  wire logic                            s_tuser,   // [0] cmd
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    // [0] trigger_level, [1] busy_res, [2] done_res, [4:3] status,
    // [20:5] distance_centi_cm, [21] obstacle
    output      logic [uer_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [uer_pkg::CFG_DAT_W-1:0]   cfg_data
);

    uer_pkg::cfg_t    cfg_reg;
    uer_pkg::result_t new_res;
    uer_pkg::result_t out_reg, out_next;
    uer_pkg::result_t skid_reg;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic             in_go;
    logic             take;
    logic             load_out;
    logic             load_skid;

    assign s_tready = !skid_valid_reg;
    assign in_go    = s_tvalid && s_tready;
    assign take     = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = uer_pkg::M_TDATA_W'(out_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks       <= uer_pkg::TIMEOUT_RST;
            cfg_reg.threshold_centi_cm  <= uer_pkg::THRESHOLD_RST;
            cfg_reg.trigger_width_ticks <= uer_pkg::TRIG_W_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                uer_pkg::CFG_TIMEOUT:   cfg_reg.timeout_ticks       <= cfg_data;
                uer_pkg::CFG_THRESHOLD: cfg_reg.threshold_centi_cm  <= cfg_data;
                uer_pkg::CFG_TRIG_W:    cfg_reg.trigger_width_ticks <= cfg_data[7:0];
                default:                ;
            endcase
        end
    end

    uer_ranging_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (in_go),
        .cmd        (s_tuser),
        .echo_level (s_tdata[0]),
        .cfg        (cfg_reg),
        .result     (new_res)
    );

    // Result register refills from skid first, then from the incoming transaction
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        if (take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                load_out        = 1'b1;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = new_res;
                load_out       = in_go;
                out_valid_next = in_go;
            end
        end
        else if (in_go)
        begin
            load_skid       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= out_next;
        end
        if (load_skid)
        begin
            skid_reg <= new_res;
        end
    end

endmodule

`default_nettype wire

[rtl/uer_checker.sv]
// Port-level assertions for ultrasonic_echo_ranger, attached by bind.
// Depends on uer_pkg.
`default_nettype none

module uer_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [uer_pkg::M_TDATA_W-1:0] m_tdata
);

    logic                   trig;
    logic                   busy;
    logic                   done;
    logic                   obst;
    logic [1:0]             stat;
    logic [15:0]            dist_val;

    assign trig     = m_tdata[uer_pkg::POS_TRIG];
    assign busy     = m_tdata[uer_pkg::POS_BUSY];
    assign done     = m_tdata[uer_pkg::POS_DONE];
    assign obst     = m_tdata[uer_pkg::POS_OBSTACLE];
    assign stat     = m_tdata[uer_pkg::POS_STATUS +: 2];
    assign dist_val = m_tdata[uer_pkg::POS_DIST +: 16];

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(done && busy))
        else $error("done and busy together");

    a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && trig |-> busy && !done)
        else $error("trigger high outside a measurement");

    a_obstacle_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && obst |-> (stat == uer_pkg::ST_OK) && (dist_val != 16'd0))
        else $error("obstacle without a valid distance");

    a_skid_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (.*);

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for ultrasonic_echo_ranger: directed ticks, long pulses, random runs.
// Depends on uer_pkg and the RTL of ultrasonic_echo_ranger; the predictor is local.
`default_nettype none

module tb;

    localparam logic [uer_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned WATCHDOG_LIMIT = 500;
    localparam int unsigned NUM_PHASES = 10;
    localparam int unsigned TICKS_PER_PHASE = 100;

    typedef enum logic [2:0] {P_IDLE, P_LOW, P_TRIG, P_WAIT, P_MEAS} ranger_phase_t;

    typedef struct {
        bit                            is_cfg;
        logic [uer_pkg::CFG_IDX_W-1:0] idx;
        logic [uer_pkg::CFG_DAT_W-1:0] val;
        bit                            cmd;
        bit                            echo;
        bit                            typed;
        uer_pkg::result_t              want;
    } row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [uer_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          s_tuser = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [uer_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          cfg_we = 1'b0;
    logic [uer_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [uer_pkg::CFG_DAT_W-1:0] cfg_data = '0;

    // predictor state and register copies
    ranger_phase_t             ph = P_IDLE;
    logic [uer_pkg::CNT_W-1:0] pulse_cnt = '0;
    logic [15:0]               last_dist = '0;
    logic [1:0]                last_stat = uer_pkg::ST_OK;
    logic                      last_obst = 1'b0;
    logic [15:0]               timeout_reg = uer_pkg::TIMEOUT_RST;
    logic [15:0]               thresh_reg = uer_pkg::THRESHOLD_RST;
    logic [7:0]                trig_w_reg = uer_pkg::TRIG_W_RST;

    uer_pkg::result_t expected_readings[$];
    row_t             rows[$];
    int unsigned      errors = 0;
    int unsigned      ticks_sent = 0;
    int unsigned      quiet_cycles = 0;
    int unsigned      stall_left = 0;
    bit               quiet = 1'b0;
    bit               gappy = 1'b1;

    ultrasonic_echo_ranger DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit rbit();
        return bit'($urandom_range(0, 1));
    endfunction

    function automatic uer_pkg::result_t reading(bit trig, bit busy, bit done,
                                                 logic [1:0] st, logic [15:0] dist_val,
                                                 bit obst);
        uer_pkg::result_t r;
        r.trigger_level     = trig;
        r.busy_res          = busy;
        r.done_res          = done;
        r.status            = st;
        r.distance_centi_cm = dist_val;
        r.obstacle          = obst;
        return r;
    endfunction

    function automatic row_t tick_row(bit cmd, bit echo, bit typed = 1'b0,
                                      uer_pkg::result_t want = '0);
        row_t r;
        r = '{default: '0};
        r.cmd   = cmd;
        r.echo  = echo;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic row_t cfg_row(logic [uer_pkg::CFG_IDX_W-1:0] idx,
                                     logic [uer_pkg::CFG_DAT_W-1:0] val);
        row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    function automatic void end_failed(logic [1:0] st);
        last_stat = st;
        last_obst = 1'b0;
        ph        = P_IDLE;
        pulse_cnt = '0;
    endfunction

    function automatic bit pulse_over();
        return (pulse_cnt >= timeout_reg) || (pulse_cnt == '1);
    endfunction

    // one microsecond tick of the ranging sequencer
    function automatic uer_pkg::result_t ranger_step(bit cmd, bit echo);
        bit          trig;
        bit          done;
        int unsigned d;
        trig = 1'b0;
        done = 1'b0;
        case (ph)
            P_IDLE:
                if (cmd)
                begin
                    if (echo)
                    begin
                        end_failed(uer_pkg::ST_STUCK);
                        done = 1'b1;
                    end
                    else
                    begin
                        ph        = P_LOW;
                        pulse_cnt = uer_pkg::CNT_W'(1);
                    end
                end
            P_LOW:
            begin
                pulse_cnt++;
                if (pulse_cnt >= uer_pkg::PRE_LOW_TICKS)
                begin
                    ph        = P_TRIG;
                    pulse_cnt = '0;
                end
            end
            P_TRIG:
            begin
                trig = 1'b1;
                pulse_cnt++;
                if (pulse_cnt >= trig_w_reg)
                begin
                    ph        = P_WAIT;
                    pulse_cnt = '0;
                end
            end
            P_WAIT:
                if (echo)
                begin
                    ph        = P_MEAS;
                    pulse_cnt = uer_pkg::CNT_W'(1);
                end
                else if (pulse_over())
                begin
                    end_failed(uer_pkg::ST_TIMEOUT);
                    done = 1'b1;
                end
                else
                    pulse_cnt++;
            P_MEAS:
                if (!echo)
                begin
                    d = (int'(pulse_cnt) * uer_pkg::DIST_MUL) >> uer_pkg::DIST_SHIFT;
                    if (d > 65535)
                        d = 65535;
                    last_dist = d[15:0];
                    last_stat = uer_pkg::ST_OK;
                    last_obst = (d > 0) && (d <= thresh_reg);
                    ph        = P_IDLE;
                    pulse_cnt = '0;
                    done      = 1'b1;
                end
                else if (pulse_over())
                begin
                    end_failed(uer_pkg::ST_TIMEOUT);
                    done = 1'b1;
                end
                else
                    pulse_cnt++;
            default:
            begin
                ph        = P_IDLE;
                pulse_cnt = '0;
            end
        endcase
        return reading(trig, ph != P_IDLE, done, last_stat, last_dist, last_obst);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    task automatic send_tick(input bit cmd, input bit echo, input bit typed = 1'b0,
                             input uer_pkg::result_t want = '0);
        uer_pkg::result_t r;
        if (!quiet && gappy && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(uer_pkg::S_TDATA_W-1){1'b0}}, echo};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = ranger_step(cmd, echo);
        expected_readings.push_back(typed ? want : r);
        ticks_sent++;
    endtask

    // hold the sender until every pending reading is back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [uer_pkg::CFG_IDX_W-1:0] idx,
                             input logic [uer_pkg::CFG_DAT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            uer_pkg::CFG_TIMEOUT:   timeout_reg = val;
            uer_pkg::CFG_THRESHOLD: thresh_reg  = val;
            uer_pkg::CFG_TRIG_W:    trig_w_reg  = val[7:0];
            default: ;
        endcase
    endtask

    // steer any running measurement to a quick ok finish
    task automatic finish_measurement();
        while (ph != P_IDLE)
            send_tick(rbit(), ph == P_WAIT);
    endtask

    task automatic set_ranger(input logic [15:0] to, input logic [15:0] th,
                              input logic [7:0] tw);
        finish_measurement();
        wait_idle();
        write_reg(uer_pkg::CFG_TIMEOUT, to);
        write_reg(uer_pkg::CFG_THRESHOLD, th);
        write_reg(uer_pkg::CFG_TRIG_W, {8'd0, tw});
    endtask

    task automatic run_measurement(input int unsigned wait_len, input int unsigned high_len,
                                   input bit noisy);
        int unsigned k;
        send_tick(1'b1, noisy ? rbit() : 1'b0);
        while (ph == P_LOW || ph == P_TRIG)
            send_tick(rbit(), rbit());
        k = 0;
        while (ph == P_WAIT && k < wait_len)
        begin
            send_tick(rbit(), noisy ? rbit() : 1'b0);
            k++;
        end
        k = 0;
        while ((ph == P_WAIT || ph == P_MEAS) && k < high_len)
        begin
            send_tick(rbit(), noisy ? rbit() : 1'b1);
            k++;
        end
        if (ph == P_MEAS)
            send_tick(rbit(), 1'b0);
        finish_measurement();
    endtask

    // receiver stalls and result checking
    always @(posedge clk)
    begin
        uer_pkg::result_t got;
        uer_pkg::result_t want;
        if (!quiet && stall_left == 0 && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 13);
        if (stall_left != 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
            m_tready <= 1'b1;

        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;

        if (rst_n && m_tvalid && m_tready)
        begin
            got = uer_pkg::result_t'(m_tdata[$bits(uer_pkg::result_t)-1:0]);
            if (expected_readings.size() == 0)
            begin
                $error("unexpected reading transaction: 0x%h", m_tdata);
                errors++;
            end
            else
            begin
                want = expected_readings.pop_front();
                check_field("trigger_level", want.trigger_level, got.trigger_level);
                check_field("busy_res", want.busy_res, got.busy_res);
                check_field("done_res", want.done_res, got.done_res);
                check_field("status", want.status, got.status);
                check_field("distance_centi_cm", want.distance_centi_cm,
                            got.distance_centi_cm);
                check_field("obstacle", want.obstacle, got.obstacle);
            end
        end
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int unsigned rand_base;
        logic [15:0] to;
        logic [15:0] th;
        logic [7:0]  tw;
        int unsigned wmax;
        int unsigned pmax;

        // after reset, stuck-high start, wait timeout, short ok pulse
        rows.push_back(tick_row(0, 0, 1, reading(0, 0, 0, uer_pkg::ST_OK, 0, 0)));
        rows.push_back(tick_row(0, 1, 1, reading(0, 0, 0, uer_pkg::ST_OK, 0, 0)));
        rows.push_back(tick_row(1, 1, 1, reading(0, 0, 1, uer_pkg::ST_STUCK, 0, 0)));
        rows.push_back(cfg_row(uer_pkg::CFG_TRIG_W, 16'd1));
        rows.push_back(cfg_row(uer_pkg::CFG_TIMEOUT, 16'd3));
        rows.push_back(cfg_row(CFG_UNUSED, 16'hFFFF));
        rows.push_back(tick_row(1, 0));
        rows.push_back(tick_row(1, 0));
        rows.push_back(tick_row(0, 1));
        rows.push_back(tick_row(0, 0));
        rows.push_back(tick_row(0, 0));
        rows.push_back(tick_row(0, 0));
        rows.push_back(tick_row(0, 0, 1, reading(0, 0, 1, uer_pkg::ST_TIMEOUT, 0, 0)));
        rows.push_back(tick_row(1, 0));
        rows.push_back(tick_row(0, 0));
        rows.push_back(tick_row(0, 0));
        rows.push_back(tick_row(0, 1));
        rows.push_back(tick_row(0, 0, 1, reading(0, 0, 1, uer_pkg::ST_OK, 1, 1)));
        // zero timeout and zero trigger width
        rows.push_back(cfg_row(uer_pkg::CFG_TIMEOUT, 16'd0));
        rows.push_back(cfg_row(uer_pkg::CFG_TRIG_W, 16'd0));
        rows.push_back(tick_row(1, 0));
        rows.push_back(tick_row(0, 0));
        rows.push_back(tick_row(0, 0));
        rows.push_back(tick_row(0, 0, 1, reading(0, 0, 1, uer_pkg::ST_TIMEOUT, 1, 0)));
        rows.push_back(tick_row(1, 0));
        rows.push_back(tick_row(0, 0));
        rows.push_back(tick_row(0, 0));
        rows.push_back(tick_row(0, 1));
        rows.push_back(tick_row(0, 1, 1, reading(0, 0, 1, uer_pkg::ST_TIMEOUT, 1, 0)));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
            begin
                finish_measurement();
                wait_idle();
                write_reg(rows[i].idx, rows[i].val);
            end
            else
                send_tick(rows[i].cmd, rows[i].echo, rows[i].typed, rows[i].want);
        end

        // long pulse with the widest timeout and threshold
        set_ranger(16'hFFFF, 16'hFFFF, 8'd2);
        run_measurement(3, 300, 1'b0);

        rand_base = ticks_sent;
        for (int unsigned p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    to = uer_pkg::TIMEOUT_RST;
                    th = uer_pkg::THRESHOLD_RST;
                    tw = uer_pkg::TRIG_W_RST;
                end
                1: begin to = 16'd1; th = 16'd0; tw = 8'd1; end
                2: begin to = 16'd2; th = 16'hFFFF; tw = 8'd255; end
                default:
                begin
                    to = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 65535))
                                                      : 16'($urandom_range(1, 40));
                    th = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 120));
                    tw = 8'($urandom_range(1, 6));
                end
            endcase
            set_ranger(to, th, tw);
            quiet = (p == NUM_PHASES - 1);
            gappy = rbit();
            wmax  = (to < 30) ? to + 1 : 30;
            pmax  = (to < 60) ? to + 1 : 60;
            while (ticks_sent < rand_base + (p + 1) * TICKS_PER_PHASE)
            begin
                if ($urandom_range(0, 9) < 7)
                    run_measurement($urandom_range(0, wmax), $urandom_range(0, pmax),
                                    $urandom_range(0, 9) == 0);
                else
                    send_tick(rbit(), rbit());
            end
        end

        wait_idle();
        repeat (3) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/uer_pkg.sv
rtl/uer_ranging_fsm.sv
rtl/ultrasonic_echo_ranger.sv
rtl/uer_checker.sv
tb/tb.sv
